// ===== rtl/piecewise_coordinate_remap_assert.svh =====
// Assertion macros for the piecewise coordinate remap checker.
// Depends on nothing; included by the checker file.
`ifndef PIECEWISE_COORDINATE_REMAP_ASSERT_SVH
`define PIECEWISE_COORDINATE_REMAP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pcr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pcr check failed");

`endif

// ===== rtl/pcr_pkg.sv =====
// Shared constants for the piecewise coordinate remap block.
// No dependencies; used by the top level and by its checker.
package pcr_pkg;

	// Field widths.
	localparam int COORD_W    = 24;
	localparam int MARGIN_W   = 23;
	localparam int COUNT_W    = 5;
	localparam int INDEX_W    = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 23;

	// Action codes of an input beat.
	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_MAP   = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_REMAP_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MARGIN_LEFT     = 2'd2;

endpackage

// ===== rtl/piecewise_coordinate_remap.sv =====
// Piecewise linear coordinate remap: with remapping on, y is remapped through a table of
// interval pairs and x has a left margin subtracted; with it off, both pass through. A write
// beat (action 0) loads one table entry in its accept cycle. A map beat with remapping on
// visits table entries in order (registered table read, then compare) and, when y is
// interpolated, goes on through one multiply, magnitude setup, a radix-4 restoring divide and
// a sign fixup. in_stall is high while a map beat is at work; one finished result can wait in
// the output register while the next beat is accepted. Table entries are undefined after
// reset and must be written before a walk reaches them; the user must write configuration
// only while the block is idle, as the block itself does not enforce it.
module piecewise_coordinate_remap #(
	parameter int MAX_PARTITIONS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// Configuration write channel.
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [pcr_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [pcr_pkg::CFG_DATA_W-1:0]       cfg_data,
	// Input channel.
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic                                 action,
	input  logic [pcr_pkg::INDEX_W-1:0]          entry_index,
	input  logic signed [pcr_pkg::COORD_W-1:0]   src_start,
	input  logic signed [pcr_pkg::COORD_W-1:0]   src_end,
	input  logic signed [pcr_pkg::COORD_W-1:0]   dst_start,
	input  logic signed [pcr_pkg::COORD_W-1:0]   dst_end,
	input  logic signed [pcr_pkg::COORD_W-1:0]   point_x,
	input  logic signed [pcr_pkg::COORD_W-1:0]   point_y,
	// Output channel.
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [pcr_pkg::COORD_W-1:0]   mapped_x,
	output logic signed [pcr_pkg::COORD_W-1:0]   mapped_y
);
	import pcr_pkg::*;

	localparam int AW        = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CW        = $clog2(MAX_PARTITIONS + 1);
	localparam int DIFF_W    = COORD_W + 1;
	localparam int DVD_W     = 2 * DIFF_W;
	localparam int DIV_STEPS = DVD_W / 2;
	localparam int STEP_W    = $clog2(DIV_STEPS);
	localparam int RES_W     = DVD_W + 2;

	typedef struct packed {
		logic [COORD_W-1:0] src_start;
		logic [COORD_W-1:0] src_end;
		logic [COORD_W-1:0] dst_start;
		logic [COORD_W-1:0] dst_end;
	} entry_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_MUL,
		ST_ABS,
		ST_DIV,
		ST_QUO,
		ST_FIN
	} state_t;

	// Sign-extend a coordinate to the result width.
	function automatic logic signed [RES_W-1:0] sext_res(input logic signed [COORD_W-1:0] v);
		sext_res = {{(RES_W-COORD_W){v[COORD_W-1]}}, v};
	endfunction

	// Clamp a wide result to the signed coordinate range.
	function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [RES_W-1:0] v);
		logic [RES_W-COORD_W:0] top;
		top = v[RES_W-1:COORD_W-1];
		if ((&top) || (~|top)) begin
			sat_coord = v[COORD_W-1:0];
		end else if (v[RES_W-1]) begin
			sat_coord = {1'b1, {(COORD_W-1){1'b0}}};
		end else begin
			sat_coord = {1'b0, {(COORD_W-1){1'b1}}};
		end
	endfunction

	// Configuration registers.
	logic                remap_enable_q;
	logic [COUNT_W-1:0]  partition_count_q;
	logic [MARGIN_W-1:0] margin_left_q;

	// Table storage and its registered read port.
	entry_t interval_mem_q [MAX_PARTITIONS];
	entry_t ent_q;

	// Sequencer and datapath registers.
	state_t                     state_q;
	logic [CW-1:0]              limit_q;
	logic [CW-1:0]              walk_idx_q;
	logic signed [COORD_W-1:0]  y_q;
	logic signed [DIFF_W-1:0]   xr_q;
	logic signed [COORD_W-1:0]  prev_src_q;
	logic signed [COORD_W-1:0]  prev_dst_q;
	logic signed [DIFF_W-1:0]   op_a_q;
	logic signed [DIFF_W-1:0]   op_b_q;
	logic signed [DIFF_W-1:0]   den_q;
	logic signed [DVD_W-1:0]    prod_q;
	logic [DVD_W-1:0]           dvd_q;
	logic [DIFF_W-1:0]          dmag_q;
	logic [DIFF_W-1:0]          rem_q;
	logic                       neg_q;
	logic [STEP_W-1:0]          step_q;
	logic signed [RES_W-1:0]    res_q;
	logic                       out_valid_q;
	logic signed [COORD_W-1:0]  mapped_x_q;
	logic signed [COORD_W-1:0]  mapped_y_q;

	logic in_beat;
	logic wr_en;
	logic out_free;

	// Entry fields as signed values.
	logic signed [COORD_W-1:0] e_src_start;
	logic signed [COORD_W-1:0] e_src_end;
	logic signed [COORD_W-1:0] e_dst_start;
	logic signed [COORD_W-1:0] e_dst_end;
	logic signed [DIFF_W-1:0]  den_c;
	logic [CW-1:0]             limit_c;
	logic [CW-1:0]             walk_next;

	// Divide step: two restoring subtractions per cycle.
	logic [DIFF_W:0]   t1;
	logic [DIFF_W:0]   t2;
	logic [DIFF_W-1:0] r1;
	logic [DIFF_W-1:0] r2;
	logic              q1;
	logic              q2;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_beat   = in_valid && !in_stall;
	assign wr_en     = in_beat && (action == ACT_WRITE) && (int'(entry_index) < MAX_PARTITIONS);
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign mapped_x  = mapped_x_q;
	assign mapped_y  = mapped_y_q;

	assign e_src_start = $signed(ent_q.src_start);
	assign e_src_end   = $signed(ent_q.src_end);
	assign e_dst_start = $signed(ent_q.dst_start);
	assign e_dst_end   = $signed(ent_q.dst_end);
	assign den_c       = $signed({e_src_start[COORD_W-1], e_src_start})
	                   - $signed({prev_src_q[COORD_W-1], prev_src_q});
	assign walk_next   = walk_idx_q + CW'(1);

	// Number of entries walked, clamped to the table depth.
	always_comb begin
		if (int'(partition_count_q) > MAX_PARTITIONS) begin
			limit_c = CW'(MAX_PARTITIONS);
		end else begin
			limit_c = CW'(partition_count_q);
		end
	end

	always_comb begin
		t1 = {rem_q, dvd_q[DVD_W-1]};
		if (t1 >= {1'b0, dmag_q}) begin
			r1 = DIFF_W'(t1 - {1'b0, dmag_q});
			q1 = 1'b1;
		end else begin
			r1 = t1[DIFF_W-1:0];
			q1 = 1'b0;
		end
		t2 = {r1, dvd_q[DVD_W-2]};
		if (t2 >= {1'b0, dmag_q}) begin
			r2 = DIFF_W'(t2 - {1'b0, dmag_q});
			q2 = 1'b1;
		end else begin
			r2 = t2[DIFF_W-1:0];
			q2 = 1'b0;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remap_enable_q    <= 1'b0;
			partition_count_q <= '0;
			margin_left_q     <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_REMAP_ENABLE: begin
					remap_enable_q <= cfg_data[0];
				end
				CFG_PARTITION_COUNT: begin
					partition_count_q <= cfg_data[COUNT_W-1:0];
				end
				CFG_MARGIN_LEFT: begin
					margin_left_q <= cfg_data[MARGIN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// Table memory: written on a write beat, read one entry per walk step.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			interval_mem_q[AW'(entry_index)] <= '{src_start: src_start, src_end: src_end,
				dst_start: dst_start, dst_end: dst_end};
		end
		if (state_q == ST_LOAD) begin
			ent_q <= interval_mem_q[walk_idx_q[AW-1:0]];
		end
	end

	// Sequencer with its datapath and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_FIN)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_beat && (action == ACT_MAP)) begin
						y_q        <= point_y;
						res_q      <= sext_res(point_y);
						prev_src_q <= '0;
						prev_dst_q <= '0;
						walk_idx_q <= '0;
						limit_q    <= limit_c;
						if (remap_enable_q) begin
							xr_q <= $signed({point_x[COORD_W-1], point_x})
							      - $signed({2'b00, margin_left_q});
							state_q <= (limit_c == '0) ? ST_FIN : ST_LOAD;
						end else begin
							xr_q    <= $signed({point_x[COORD_W-1], point_x});
							state_q <= ST_FIN;
						end
					end
				end
				ST_LOAD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (y_q <= e_src_start) begin
						if (den_c == '0) begin
							res_q   <= sext_res(e_dst_start);
							state_q <= ST_FIN;
						end else begin
							op_a_q  <= $signed({y_q[COORD_W-1], y_q})
							         - $signed({prev_src_q[COORD_W-1], prev_src_q});
							op_b_q  <= $signed({e_dst_start[COORD_W-1], e_dst_start})
							         - $signed({prev_dst_q[COORD_W-1], prev_dst_q});
							den_q   <= den_c;
							state_q <= ST_MUL;
						end
					end else if (y_q <= e_src_end) begin
						res_q   <= sext_res(y_q) - sext_res(e_src_start) + sext_res(e_dst_start);
						state_q <= ST_FIN;
					end else begin
						prev_src_q <= e_src_end;
						prev_dst_q <= e_dst_end;
						walk_idx_q <= walk_next;
						state_q    <= (walk_next == limit_q) ? ST_FIN : ST_LOAD;
					end
				end
				ST_MUL: begin
					prod_q  <= op_a_q * op_b_q;
					state_q <= ST_ABS;
				end
				ST_ABS: begin
					// Divide magnitudes; the quotient sign is applied afterwards.
					dvd_q   <= prod_q[DVD_W-1] ? DVD_W'(-prod_q) : DVD_W'(prod_q);
					dmag_q  <= den_q[DIFF_W-1] ? DIFF_W'(-den_q) : DIFF_W'(den_q);
					neg_q   <= prod_q[DVD_W-1] ^ den_q[DIFF_W-1];
					rem_q   <= '0;
					step_q  <= STEP_W'(DIV_STEPS - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= r2;
					dvd_q <= {dvd_q[DVD_W-3:0], q1, q2};
					if (step_q == '0) begin
						state_q <= ST_QUO;
					end else begin
						step_q <= step_q - STEP_W'(1);
					end
				end
				ST_QUO: begin
					if (neg_q) begin
						res_q <= sext_res(prev_dst_q) - $signed({2'b00, dvd_q});
					end else begin
						res_q <= sext_res(prev_dst_q) + $signed({2'b00, dvd_q});
					end
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						mapped_x_q  <= sat_coord(RES_W'(xr_q));
						mapped_y_q  <= sat_coord(res_q);
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/pcr_checker.sv =====
// Port-level checker for the piecewise coordinate remap block, bound to its top level.
// Depends on pcr_pkg and on the assertion macros in piecewise_coordinate_remap_assert.svh.
`include "piecewise_coordinate_remap_assert.svh"

module pcr_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_stall,
	input logic                                action,
	input logic                                out_valid,
	input logic                                out_stall,
	input logic signed [pcr_pkg::COORD_W-1:0]  mapped_x,
	input logic signed [pcr_pkg::COORD_W-1:0]  mapped_y
);
	import pcr_pkg::*;

	// A result held back by the sink keeps its value.
	`PCR_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(mapped_x) && $stable(mapped_y))

	// A table write never produces a result beat.
	`PCR_ASSERT_NEXT(a_write_silent, clk, arst_n, in_valid && !in_stall && (action == ACT_WRITE) && !out_valid, !out_valid)

	// A map beat occupies the block for at least the following cycle.
	`PCR_ASSERT_NEXT(a_map_busy, clk, arst_n, in_valid && !in_stall && (action == ACT_MAP), in_stall)

	// A new result appears only out of a busy period.
	`PCR_ASSERT_NOW(a_result_from_work, clk, arst_n, $rose(out_valid), $past(in_stall))

endmodule

bind piecewise_coordinate_remap pcr_checker u_pcr_checker (.*);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the piecewise coordinate remap block: directed and random beats,
// with every result checked against an in-bench model of the interval walk.
// Depends on pcr_pkg and the piecewise_coordinate_remap top level.
module tb;
	import pcr_pkg::*;

	localparam int MAX_ENTRIES = 16;
	localparam int DRAIN_CYCLES = 80;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam longint COORD_HI = 64'sd8388607;
	localparam longint COORD_LO = -64'sd8388608;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef struct {
		logic signed [COORD_W-1:0] src_start;
		logic signed [COORD_W-1:0] src_end;
		logic signed [COORD_W-1:0] dst_start;
		logic signed [COORD_W-1:0] dst_end;
	} interval_t;

	typedef struct {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
	} point_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic action = ACT_WRITE;
	logic [INDEX_W-1:0] entry_index = '0;
	logic signed [COORD_W-1:0] src_start = '0;
	logic signed [COORD_W-1:0] src_end = '0;
	logic signed [COORD_W-1:0] dst_start = '0;
	logic signed [COORD_W-1:0] dst_end = '0;
	logic signed [COORD_W-1:0] point_x = '0;
	logic signed [COORD_W-1:0] point_y = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] mapped_x;
	logic signed [COORD_W-1:0] mapped_y;

	// Shadow state of the block: interval table and register values.
	interval_t iv_table [MAX_ENTRIES];
	logic remap_on = 1'b0;
	logic [COUNT_W-1:0] part_count = '0;
	logic [MARGIN_W-1:0] margin = '0;

	point_t expected_points [$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	bit idle_on = 1'b1;

	piecewise_coordinate_remap DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.entry_index(entry_index),
		.src_start(src_start),
		.src_end(src_end),
		.dst_start(dst_start),
		.dst_end(dst_end),
		.point_x(point_x),
		.point_y(point_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.mapped_x(mapped_x),
		.mapped_y(mapped_y)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic logic signed [COORD_W-1:0] clamp_coord(input longint v);
		if (v > COORD_HI) return COORD_HI[COORD_W-1:0];
		if (v < COORD_LO) return COORD_LO[COORD_W-1:0];
		return v[COORD_W-1:0];
	endfunction

	function automatic logic signed [COORD_W-1:0] rand_coord();
		return COORD_W'($urandom);
	endfunction

	// Walk the active entries in order; stop at the first one that brackets y.
	function automatic longint walk_intervals(input longint y);
		longint prev_src, prev_dst, s_start, s_end, d_start, den;
		int n;
		prev_src = 0;
		prev_dst = 0;
		n = (part_count > MAX_ENTRIES) ? MAX_ENTRIES : part_count;
		for (int i = 0; i < n; i++) begin
			s_start = iv_table[i].src_start;
			s_end = iv_table[i].src_end;
			d_start = iv_table[i].dst_start;
			if (y <= s_start) begin
				den = s_start - prev_src;
				if (den == 0) return d_start;
				// Signed division truncates toward zero.
				return prev_dst + ((y - prev_src) * (d_start - prev_dst)) / den;
			end
			if (y <= s_end) return y - (s_start - d_start);
			prev_src = s_end;
			prev_dst = iv_table[i].dst_end;
		end
		return y;
	endfunction

	function automatic point_t remap_point(input logic signed [COORD_W-1:0] px, py);
		longint x, y;
		point_t r;
		x = px;
		y = py;
		if (remap_on) begin
			y = walk_intervals(y);
			x = x - longint'(margin);
		end
		r.x = clamp_coord(x);
		r.y = clamp_coord(y);
		return r;
	endfunction

	function void note_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10) $display("%s", msg);
	endfunction

	// Send one input beat, after a random gap while idling is on, and update the shadow state when it is taken.
	task automatic send_beat(input logic act, input logic [INDEX_W-1:0] idx,
			input logic signed [COORD_W-1:0] ss, se, ds, de, px, py);
		int gap;
		gap = idle_on ? $urandom_range(0, 3) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		entry_index <= idx;
		src_start <= ss;
		src_end <= se;
		dst_start <= ds;
		dst_end <= de;
		point_x <= px;
		point_y <= py;
		do @(posedge clk); while (in_stall);
		if (act == ACT_WRITE) begin
			iv_table[idx] = '{ss, se, ds, de};
		end else begin
			expected_points.push_back(remap_point(px, py));
		end
	endtask

	// Write beats carry random point fields, map beats random table fields.
	task automatic write_entry(input logic [INDEX_W-1:0] idx,
			input logic signed [COORD_W-1:0] ss, se, ds, de);
		send_beat(ACT_WRITE, idx, ss, se, ds, de, rand_coord(), rand_coord());
	endtask

	task automatic map_point(input logic signed [COORD_W-1:0] px, py);
		send_beat(ACT_MAP, INDEX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
			rand_coord(), px, py);
	endtask

	// The caller lowers cfg_valid after its last register write.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_REMAP_ENABLE: remap_on = data[0];
			CFG_PARTITION_COUNT: part_count = data[COUNT_W-1:0];
			CFG_MARGIN_LEFT: margin = data[MARGIN_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic en, input logic [COUNT_W-1:0] cnt,
			input logic [MARGIN_W-1:0] mgn);
		write_reg(CFG_REMAP_ENABLE, CFG_DATA_W'(en));
		write_reg(CFG_PARTITION_COUNT, CFG_DATA_W'(cnt));
		write_reg(CFG_MARGIN_LEFT, CFG_DATA_W'(mgn));
		cfg_valid <= 1'b0;
	endtask

	// Wait until every result is in, then give a trailing write beat time to finish.
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (expected_points.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Remap off after reset: coordinates pass through. Also loads the whole table.
	task automatic test_passthrough();
		map_point(COORD_HI[COORD_W-1:0], COORD_LO[COORD_W-1:0]);
		map_point(COORD_LO[COORD_W-1:0], COORD_HI[COORD_W-1:0]);
		write_entry(0, 100, 1000, COORD_HI[COORD_W-1:0], 1500);
		write_entry(1, 2000, 3000, 4000, 4000);
		write_entry(2, 5000, 6000, 100, 200);
		for (int i = 3; i < MAX_ENTRIES; i++) begin
			write_entry(INDEX_W'(i), COORD_W'(7000 + 1000 * (i - 3)),
				COORD_W'(7500 + 1000 * (i - 3)), COORD_W'(-100 * i), COORD_W'(100 * i));
		end
	endtask

	// Full walk with the widest margin: interpolation, shift, fall-through and saturation.
	task automatic test_interval_walk();
		settle_idle();
		set_regs(1'b1, COUNT_W'(MAX_ENTRIES), {MARGIN_W{1'b1}});
		map_point(COORD_LO[COORD_W-1:0], COORD_LO[COORD_W-1:0]);
		map_point(COORD_HI[COORD_W-1:0], 50);
		map_point(0, 100);
		map_point(1, 500);
		map_point(-1, 1500);
		map_point(123, 3001);
		map_point(COORD_HI[COORD_W-1:0], COORD_HI[COORD_W-1:0]);
	endtask

	// Count above the table size, count of zero, and a write to the unused register index.
	task automatic test_count_limits();
		settle_idle();
		write_reg(CFG_PARTITION_COUNT, CFG_DATA_W'({COUNT_W{1'b1}}));
		write_reg(CFG_MARGIN_LEFT, '0);
		cfg_valid <= 1'b0;
		map_point(COORD_LO[COORD_W-1:0], 19200);
		map_point(COORD_HI[COORD_W-1:0], COORD_HI[COORD_W-1:0]);
		settle_idle();
		write_reg(CFG_PARTITION_COUNT, '0);
		write_reg(CFG_UNUSED_INDEX, {CFG_DATA_W{1'b1}});
		cfg_valid <= 1'b0;
		map_point(5, 500);
	endtask

	// First entry starting at zero: y at or below it takes the destination start.
	task automatic test_zero_divisor();
		write_entry(0, 0, 1000, -777, 1500);
		settle_idle();
		set_regs(1'b1, 1, 0);
		map_point(7, -5);
		map_point(-7, 0);
		map_point(0, COORD_LO[COORD_W-1:0]);
	endtask

	// Reload the table with ascending source intervals of a random scale.
	task automatic load_sorted_table();
		longint src_pos, dst_pos, s0, s1, d0, d1;
		int step_bits;
		bit dst_sorted;
		step_bits = $urandom_range(1, 19);
		dst_sorted = 1'($urandom_range(0, 1));
		src_pos = -longint'($urandom_range(0, 1 << 23));
		dst_pos = -longint'($urandom_range(0, 1 << 23));
		for (int i = 0; i < MAX_ENTRIES; i++) begin
			s0 = src_pos;
			src_pos += $urandom_range(0, 1 << step_bits);
			s1 = src_pos;
			src_pos += $urandom_range(0, 1 << step_bits);
			if (dst_sorted) begin
				d0 = dst_pos;
				dst_pos += $urandom_range(0, 1 << step_bits);
				d1 = dst_pos;
				dst_pos += $urandom_range(0, 1 << step_bits);
			end else begin
				d0 = rand_coord();
				d1 = rand_coord();
			end
			write_entry(INDEX_W'(i), clamp_coord(s0), clamp_coord(s1), clamp_coord(d0),
				clamp_coord(d1));
		end
	endtask

	// Points near interval edges or gap midpoints, or random ones, so every branch of the walk is hit.
	function automatic logic signed [COORD_W-1:0] pick_y();
		int e, jitter;
		longint base;
		e = $urandom_range(0, MAX_ENTRIES - 1);
		jitter = $urandom_range(0, 4);
		case ($urandom_range(0, 3))
			0: return rand_coord();
			1: base = iv_table[e].src_start;
			2: base = iv_table[e].src_end;
			default: base = (e == 0) ? 0 :
				(longint'(iv_table[e - 1].src_end) + iv_table[e].src_start) / 2;
		endcase
		return clamp_coord(base + jitter - 2);
	endfunction

	task automatic test_random(input int n_items);
		int sent, round;
		logic [COUNT_W-1:0] cnt;
		logic [MARGIN_W-1:0] mgn;
		logic signed [COORD_W-1:0] px;
		sent = 0;
		round = 0;
		while (sent < n_items) begin
			settle_idle();
			// Every fourth round runs with no idling on either side.
			idle_on = (round % 4) != 3;
			case ($urandom_range(0, 5))
				0: cnt = 0;
				1: cnt = COUNT_W'(MAX_ENTRIES);
				2: cnt = {COUNT_W{1'b1}};
				3: cnt = 1;
				default: cnt = COUNT_W'($urandom_range(0, 31));
			endcase
			case ($urandom_range(0, 3))
				0: mgn = '0;
				1: mgn = {MARGIN_W{1'b1}};
				2: mgn = MARGIN_W'($urandom_range(0, 1 << 12));
				default: mgn = MARGIN_W'($urandom);
			endcase
			set_regs($urandom_range(0, 3) != 0, cnt, mgn);
			if ($urandom_range(0, 1)) begin
				load_sorted_table();
				sent += MAX_ENTRIES;
			end
			repeat (30) begin
				if ($urandom_range(0, 9) == 0) begin
					write_entry(INDEX_W'($urandom), rand_coord(), rand_coord(), rand_coord(),
						rand_coord());
				end else begin
					case ($urandom_range(0, 7))
						0: px = COORD_LO[COORD_W-1:0];
						1: px = COORD_HI[COORD_W-1:0];
						default: px = rand_coord();
					endcase
					map_point(px, pick_y());
				end
				sent++;
			end
			round++;
		end
	endtask

	// Result side: while idling is on, a random number of stall cycles before each beat is taken.
	initial begin
		int stall_cycles;
		forever begin
			stall_cycles = idle_on ? $urandom_range(0, 3) : 0;
			if (stall_cycles != 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(posedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!out_valid);
		end
	end

	// Compare each result beat with the oldest expected point.
	always @(posedge clk) begin
		point_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_points.size() == 0) begin
				note_error($sformatf("unexpected result: x=%0d y=%0d", mapped_x, mapped_y));
			end else begin
				want = expected_points.pop_front();
				if (mapped_x !== want.x || mapped_y !== want.y) begin
					note_error($sformatf("mismatch: x=%0d (want %0d) y=%0d (want %0d)",
						mapped_x, want.x, mapped_y, want.y));
				end
			end
		end
	end

	// Watchdog on cycles in which no channel moves a beat.
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		foreach (iv_table[i]) iv_table[i] = '{0, 0, 0, 0};
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_passthrough();
		test_interval_walk();
		test_count_limits();
		test_zero_divisor();
		test_random(770);
		settle_idle();
		if (mismatch_count == 0 && expected_points.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
